### rtl/dtt_pkg.sv
`default_nettype none

package dtt_pkg;

	// Table size used when the top level is not given one.
	localparam int DEFAULT_TABLE_DEPTH = 16;

	// Request codes.
	localparam logic [1:0] ACT_ADD    = 2'd0;
	localparam logic [1:0] ACT_CANCEL = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;
	localparam logic [1:0] ACT_FIRE   = 2'd3;

	// Response status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_NONE      = 2'd3;

	// Query conversion from microseconds to milliseconds, rounded up.
	// Differences at or above the clamp limit give the largest timeout;
	// anything below it, plus the rounding term, fits in DIV_BITS bits.
	// The divide by 1000 takes that dividend as DIV_DIGITS digits of DIGIT_W bits,
	// most significant first. Each partial dividend (remainder and next digit) is
	// below 2^31, where a multiply by RECIP and a shift by RECIP_SHIFT give the
	// exact quotient.
	localparam logic signed [31:0] TIMEOUT_MAX   = 32'sd2147483647;
	localparam logic signed [31:0] TIMEOUT_EMPTY = -32'sd1;
	localparam logic signed [31:0] TIMEOUT_ZERO  = 32'sd0;
	localparam logic [63:0]        CLAMP_LIMIT   = 64'd2147483647000;
	localparam int                 DIV_BITS      = 42;
	localparam int                 DIGIT_W       = 21;
	localparam int                 DIV_DIGITS    = 2;
	localparam int                 REM_W         = 10;
	localparam int                 PART_W        = 31;
	localparam int                 QUO_W         = 31;
	localparam int                 STEP_W        = 1;
	localparam int                 RECIP_W       = 32;
	localparam int                 RECIP_SHIFT   = 41;
	localparam logic [RECIP_W-1:0] RECIP         = 32'd2199023256;
	localparam logic [DIV_BITS-1:0] ROUND_UP     = 42'd999;
	localparam logic [PART_W-1:0]  DIVISOR       = 31'd1000;

	// One request beat.
	typedef struct packed {
		logic [1:0]  action;
		logic [63:0] now_usec;
		logic [63:0] delay_us;
		logic [63:0] cancel_id;
	} req_t;

	// One response beat.
	typedef struct packed {
		logic [1:0]         status;
		logic [63:0]        timer_id;
		logic signed [31:0] timeout_ms;
		logic               last;
	} rsp_t;

endpackage

`default_nettype wire

### rtl/dtt_ram.sv
`default_nettype none

module dtt_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### rtl/deadline_timer_table.sv
// Deadline timer table: holds up to TABLE_DEPTH one-shot timers, each an id and an absolute
// deadline in microseconds, in one RAM of id/deadline pairs with a registered read port. One
// request is taken at a time; req_ready is high only while the sequencer is idle. Cancel,
// query and fire walk the table one slot at a time, each slot a RAM read then a compare.
// Each fired timer, and a found cancel, moves the last entry into the freed slot with a RAM
// read and a write; a fired slot is then read and compared again. A query with a future
// deadline goes on to a clamp test and, below the clamp, to the divide by 1000 (two 21-bit
// digits, each a reciprocal multiply followed by a remainder step). Responses leave through a
// single output register, so a stalled rsp_ready slows a fire that has several timers due.
// Fire responses are held back by one, so that the final one can carry last. No clearing pass
// is needed after reset; only slots below the live count are ever read.
`default_nettype none

module deadline_timer_table
	import dtt_pkg::*;
#(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int EW = 128;
	localparam int PROD_W = PART_W + RECIP_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD,
		S_READ,
		S_CHECK,
		S_FHIT,
		S_MOVE_RD,
		S_MOVE_WR,
		S_FEND,
		S_QDIFF,
		S_QCLAMP,
		S_DIV,
		S_DREM,
		S_EMIT
	} state_t;

	state_t                 state_q;
	req_t                   req_q;
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          idx_q;
	logic [63:0]            next_id_q;
	logic [63:0]            min_q;
	logic [63:0]            diff_q;
	logic [63:0]            hit_q;
	logic [63:0]            pend_q;
	logic                   pend_valid_q;
	rsp_t                   res_q;
	rsp_t                   rsp_q;
	logic                   rsp_valid_q;
	logic [DIV_BITS-1:0]    dvd_q;
	logic [REM_W-1:0]       rem_q;
	logic [QUO_W-1:0]       quo_q;
	logic [DIGIT_W-1:0]     digit_q;
	logic [STEP_W-1:0]      step_q;

	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [EW-1:0]          ram_wdata;
	logic [AW-1:0]          ram_raddr;
	logic [EW-1:0]          ram_rdata;

	logic [63:0]            ent_id;
	logic [63:0]            ent_dl;
	logic [CW-1:0]          idx_inc;
	logic                   at_end;
	logic                   out_free;
	logic                   rsp_load;
	logic [PART_W-1:0]      part;
	logic [PROD_W-1:0]      part_prod;
	logic [PART_W-1:0]      part_back;
	logic [PART_W-1:0]      part_rem;

	// Entry layout in the RAM: id in the upper half, deadline in the lower half.
	assign ent_id  = ram_rdata[EW-1:64];
	assign ent_dl  = ram_rdata[63:0];
	assign idx_inc = idx_q + CW'(1);
	assign at_end  = (idx_inc == count_q);
	assign out_free = !rsp_valid_q || rsp_ready;

	// A beat goes out from S_EMIT, and from S_FHIT when an earlier fired id is waiting.
	assign rsp_load = out_free && ((state_q == S_EMIT) || (state_q == S_FHIT && pend_valid_q));

	// Partial dividend of the current digit, its quotient by reciprocal multiplication,
	// and what is left once that quotient times 1000 is taken back off.
	assign part      = {rem_q, dvd_q[DIV_BITS-1 -: DIGIT_W]};
	assign part_prod = PROD_W'(part) * PROD_W'(RECIP);
	assign part_back = PART_W'(digit_q) * DIVISOR;
	assign part_rem  = part - part_back;

	// Table port control: writes for add and for the slot refill, reads for the walk.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[AW-1:0];
		ram_wdata = ram_rdata;
		ram_raddr = idx_q[AW-1:0];
		unique case (state_q)
			S_ADD: begin
				ram_we    = (count_q != CW'(TABLE_DEPTH));
				ram_waddr = count_q[AW-1:0];
				ram_wdata = {next_id_q, req_q.now_usec + req_q.delay_us};
			end
			S_MOVE_RD: begin
				ram_raddr = count_q[AW-1:0];
			end
			S_MOVE_WR: begin
				ram_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	dtt_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Sequencer with the response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			next_id_q    <= 64'd1;
			pend_valid_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q          <= req;
						idx_q          <= '0;
						min_q          <= '1;
						pend_valid_q   <= 1'b0;
						res_q.timer_id <= '0;
						res_q.last     <= 1'b1;
						// An empty table answers cancel, query and fire at once.
						unique case (req.action)
							ACT_ADD: begin
								res_q.status     <= ST_OK;
								res_q.timeout_ms <= TIMEOUT_ZERO;
								state_q          <= S_ADD;
							end
							ACT_CANCEL: begin
								res_q.timeout_ms <= TIMEOUT_ZERO;
								if (count_q == '0) begin
									res_q.status <= ST_NOT_FOUND;
									state_q      <= S_EMIT;
								end else begin
									res_q.status <= ST_OK;
									state_q      <= S_READ;
								end
							end
							ACT_QUERY: begin
								res_q.status <= ST_OK;
								if (count_q == '0) begin
									res_q.timeout_ms <= TIMEOUT_EMPTY;
									state_q          <= S_EMIT;
								end else begin
									res_q.timeout_ms <= TIMEOUT_ZERO;
									state_q          <= S_READ;
								end
							end
							default: begin
								res_q.timeout_ms <= TIMEOUT_ZERO;
								if (count_q == '0) begin
									res_q.status <= ST_NONE;
									state_q      <= S_EMIT;
								end else begin
									res_q.status <= ST_OK;
									state_q      <= S_READ;
								end
							end
						endcase
					end
				end
				S_ADD: begin
					if (count_q == CW'(TABLE_DEPTH)) begin
						res_q.status <= ST_FULL;
					end else begin
						res_q.timer_id <= next_id_q;
						next_id_q      <= next_id_q + 64'd1;
						count_q        <= count_q + CW'(1);
					end
					state_q <= S_EMIT;
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					unique case (req_q.action)
						ACT_CANCEL: begin
							if (ent_id == req_q.cancel_id) begin
								res_q.timer_id <= req_q.cancel_id;
								count_q        <= count_q - CW'(1);
								state_q        <= S_MOVE_RD;
							end else if (at_end) begin
								res_q.status <= ST_NOT_FOUND;
								state_q      <= S_EMIT;
							end else begin
								idx_q   <= idx_inc;
								state_q <= S_READ;
							end
						end
						ACT_QUERY: begin
							if (ent_dl < min_q) begin
								min_q <= ent_dl;
							end
							if (at_end) begin
								state_q <= S_QDIFF;
							end else begin
								idx_q   <= idx_inc;
								state_q <= S_READ;
							end
						end
						default: begin
							if (ent_dl <= req_q.now_usec) begin
								hit_q   <= ent_id;
								state_q <= S_FHIT;
							end else if (at_end) begin
								state_q <= S_FEND;
							end else begin
								idx_q   <= idx_inc;
								state_q <= S_READ;
							end
						end
					endcase
				end
				// Send the previously fired id (not last), then hold the new one back.
				S_FHIT: begin
					if (!pend_valid_q || out_free) begin
						if (pend_valid_q) begin
							rsp_q.status     <= ST_OK;
							rsp_q.timer_id   <= pend_q;
							rsp_q.timeout_ms <= TIMEOUT_ZERO;
							rsp_q.last       <= 1'b0;
						end
						pend_q       <= hit_q;
						pend_valid_q <= 1'b1;
						count_q      <= count_q - CW'(1);
						state_q      <= S_MOVE_RD;
					end
				end
				S_MOVE_RD: begin
					state_q <= S_MOVE_WR;
				end
				// The last entry is written into the freed slot.
				S_MOVE_WR: begin
					if (req_q.action == ACT_CANCEL) begin
						state_q <= S_EMIT;
					end else if (idx_q == count_q) begin
						state_q <= S_FEND;
					end else begin
						state_q <= S_READ;
					end
				end
				S_FEND: begin
					if (pend_valid_q) begin
						res_q.timer_id <= pend_q;
					end else begin
						res_q.status <= ST_NONE;
					end
					state_q <= S_EMIT;
				end
				S_QDIFF: begin
					if (min_q <= req_q.now_usec) begin
						state_q <= S_EMIT;
					end else begin
						diff_q  <= min_q - req_q.now_usec;
						state_q <= S_QCLAMP;
					end
				end
				S_QCLAMP: begin
					if (diff_q >= CLAMP_LIMIT) begin
						res_q.timeout_ms <= TIMEOUT_MAX;
						state_q          <= S_EMIT;
					end else begin
						dvd_q   <= diff_q[DIV_BITS-1:0] + ROUND_UP;
						rem_q   <= '0;
						quo_q   <= '0;
						step_q  <= '0;
						state_q <= S_DIV;
					end
				end
				// Quotient digit of the current partial dividend.
				S_DIV: begin
					digit_q <= part_prod[RECIP_SHIFT +: DIGIT_W];
					state_q <= S_DREM;
				end
				// Keep the remainder, append the digit and move on to the next digit.
				S_DREM: begin
					rem_q  <= part_rem[REM_W-1:0];
					quo_q  <= {quo_q[QUO_W-DIGIT_W-1:0], digit_q};
					dvd_q  <= {dvd_q[DIV_BITS-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(DIV_DIGITS - 1)) begin
						res_q.timeout_ms <= signed'({1'b0, quo_q[QUO_W-DIGIT_W-1:0], digit_q});
						state_q          <= S_EMIT;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						rsp_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

### rtl/dtt_checker.sv
`default_nettype none

module dtt_checker
	import dtt_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire req_t req,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire rsp_t rsp
);

	// A waiting request beat stays put.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("request beat changed while waiting");

	// A stalled response beat stays put.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response beat changed while stalled");

	// The block works on one request at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// Failure and empty-fire beats end the response and carry no id.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.last && rsp.timer_id == 64'd0)
		else $error("non-ok beat not final or carries an id");

	// A non-zero timeout only comes from a query, which carries no id.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.timeout_ms != TIMEOUT_ZERO
		|-> rsp.status == ST_OK && rsp.timer_id == 64'd0 && rsp.last)
		else $error("timeout on a beat that is not a query result");

endmodule

bind deadline_timer_table dtt_checker u_dtt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import dtt_pkg::*;

	localparam int DEPTH        = DEFAULT_TABLE_DEPTH;
	localparam int RANDOM_ITEMS = 405;
	localparam int LIMIT_CYCLES = 1500000;
	localparam int SETTLE_CYCLES = 150;
	localparam logic [63:0] ALL_ONES = '1;
	localparam logic [63:0] INT_LIMIT = 64'd2147483647;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	deadline_timer_table #(
		.TABLE_DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #2 clk = ~clk;

	// Shadow copy of the timer table, updated as each request beat is taken.
	logic [63:0] shadow_ids [DEPTH];
	logic [63:0] shadow_dls [DEPTH];
	int          shadow_live = 0;
	logic [63:0] shadow_next_id = 64'd1;

	req_t pending_reqs [$];
	rsp_t awaited_rsps [$];
	int   mismatches = 0;
	bit   calm = 1'b0;
	bit   req_held = 1'b0;
	int   send_gap = 0;
	int   stall_left = 0;
	logic [63:0] clock_us = 64'd0;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Mostly short gaps, a few long ones, none at all during calm stretches.
	function automatic int pick_gap();
		int roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Remove a slot by moving the last live entry into it.
	task automatic drop_slot(int slot);
		shadow_live--;
		shadow_ids[slot] = shadow_ids[shadow_live];
		shadow_dls[slot] = shadow_dls[shadow_live];
	endtask

	// Work out the responses of one request and update the shadow table.
	task automatic table_apply(req_t r);
		rsp_t        res;
		logic [63:0] earliest;
		logic [63:0] gap_us;
		logic [63:0] ms;
		logic [63:0] fired_ids [$];
		int          i;
		bit          found;
		res = '0;
		res.status = ST_OK;
		res.last = 1'b1;
		case (r.action)
			ACT_ADD: begin
				if (shadow_live >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					shadow_ids[shadow_live] = shadow_next_id;
					shadow_dls[shadow_live] = r.now_usec + r.delay_us;
					shadow_live++;
					res.timer_id = shadow_next_id;
					shadow_next_id = shadow_next_id + 64'd1;
				end
				awaited_rsps.push_back(res);
			end
			ACT_CANCEL: begin
				found = 1'b0;
				for (i = 0; i < shadow_live && !found; i++) begin
					if (shadow_ids[i] == r.cancel_id) begin
						drop_slot(i);
						found = 1'b1;
					end
				end
				if (found)
					res.timer_id = r.cancel_id;
				else
					res.status = ST_NOT_FOUND;
				awaited_rsps.push_back(res);
			end
			ACT_QUERY: begin
				if (shadow_live == 0) begin
					res.timeout_ms = TIMEOUT_EMPTY;
				end else begin
					earliest = ALL_ONES;
					for (i = 0; i < shadow_live; i++)
						if (shadow_dls[i] < earliest)
							earliest = shadow_dls[i];
					if (earliest <= r.now_usec) begin
						res.timeout_ms = TIMEOUT_ZERO;
					end else begin
						// Round up to whole milliseconds; the floor test keeps the sum in range.
						gap_us = earliest - r.now_usec;
						if (gap_us / 64'd1000 >= INT_LIMIT) begin
							res.timeout_ms = TIMEOUT_MAX;
						end else begin
							ms = (gap_us + 64'd999) / 64'd1000;
							res.timeout_ms = ms[31:0];
						end
					end
				end
				awaited_rsps.push_back(res);
			end
			ACT_FIRE: begin
				// A refilled slot is checked again before moving on.
				i = 0;
				while (i < shadow_live) begin
					if (shadow_dls[i] <= r.now_usec) begin
						fired_ids.push_back(shadow_ids[i]);
						drop_slot(i);
					end else begin
						i++;
					end
				end
				if (fired_ids.size() == 0) begin
					res.status = ST_NONE;
					awaited_rsps.push_back(res);
				end else begin
					for (i = 0; i < fired_ids.size(); i++) begin
						res.timer_id = fired_ids[i];
						res.last = (i == fired_ids.size() - 1);
						awaited_rsps.push_back(res);
					end
				end
			end
		endcase
	endtask

	task automatic flag_field(string field, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
		end
	endtask

	// Request side: present queued beats, with gaps after each accepted one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && req_ready) begin
				table_apply(req);
				req_held = 1'b0;
			end
			if (!req_held) begin
				if (send_gap > 0) begin
					send_gap--;
					req_valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					req <= pending_reqs.pop_front();
					req_valid <= 1'b1;
					req_held = 1'b1;
					send_gap = pick_gap();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Response side: check each beat against the oldest expectation, stall at random.
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (awaited_rsps.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected response, expected none, got %p", $time, rsp);
				end else begin
					want = awaited_rsps.pop_front();
					flag_field("status", 64'(want.status), 64'(rsp.status));
					flag_field("timer_id", want.timer_id, rsp.timer_id);
					flag_field("timeout_ms", 64'(want.timeout_ms), 64'(rsp.timeout_ms));
					flag_field("last", 64'(want.last), 64'(rsp.last));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	function automatic req_t make_req(logic [1:0] act, logic [63:0] now,
			logic [63:0] delay, logic [63:0] cid);
		req_t r;
		r.action = act;
		r.now_usec = now;
		r.delay_us = delay;
		r.cancel_id = cid;
		return r;
	endfunction

	// One random request around a slowly advancing clock; unused fields carry noise.
	function automatic req_t random_req();
		req_t r;
		int   roll;
		int   sel;
		r = make_req(ACT_QUERY, clock_us, rand64(), rand64());
		clock_us = clock_us + $urandom_range(0, 2500);
		roll = $urandom_range(0, 99);
		if (roll < 35) begin
			r.action = ACT_ADD;
			sel = $urandom_range(0, 19);
			if (sel == 1)
				r.delay_us = 64'd2147483646000 + $urandom_range(0, 2000);
			else if (sel != 0)
				r.delay_us = $urandom_range(0, 20000);
		end else if (roll < 55) begin
			r.action = ACT_CANCEL;
			sel = $urandom_range(0, 19);
			if (sel < 12 && shadow_live > 0)
				r.cancel_id = shadow_ids[$urandom_range(0, shadow_live - 1)];
			else if (sel < 16)
				r.cancel_id = shadow_next_id - $urandom_range(1, 6);
		end else if (roll >= 75) begin
			r.action = ACT_FIRE;
		end
		if ($urandom_range(0, 15) == 0)
			r.now_usec = rand64();
		else if (r.action == ACT_FIRE && $urandom_range(0, 11) == 0)
			r.now_usec = ALL_ONES;
		return r;
	endfunction

	task automatic send(req_t r);
		pending_reqs.push_back(r);
		while (pending_reqs.size() > 1)
			@(negedge clk);
	endtask

	// Hold the sender back until every awaited response has arrived.
	task automatic drain();
		while (pending_reqs.size() != 0 || req_held || awaited_rsps.size() != 0)
			@(negedge clk);
	endtask

	// Cycle limit on the whole run.
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("** deadline_timer_table: FAILED **");
		$finish;
	end

	initial begin
		int items_left;
		int burst;
		int phase;
		int k;
		logic [63:0] far_dl;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: empty table, boundaries of due, rounding, wrap and clamp.
		far_dl = ALL_ONES - 64'd1;
		send(make_req(ACT_QUERY, 64'd0, rand64(), rand64()));
		send(make_req(ACT_FIRE, 64'd0, rand64(), rand64()));
		send(make_req(ACT_CANCEL, rand64(), rand64(), 64'd0));
		send(make_req(ACT_CANCEL, rand64(), rand64(), ALL_ONES));
		send(make_req(ACT_ADD, 64'd100, 64'd1, rand64()));
		send(make_req(ACT_QUERY, 64'd100, rand64(), rand64()));
		send(make_req(ACT_ADD, 64'd0, 64'd2000, rand64()));
		send(make_req(ACT_QUERY, 64'd1000, rand64(), rand64()));
		send(make_req(ACT_FIRE, 64'd101, rand64(), rand64()));
		send(make_req(ACT_QUERY, 64'd1000, rand64(), rand64()));
		send(make_req(ACT_QUERY, 64'd999, rand64(), rand64()));
		send(make_req(ACT_ADD, 64'd0, ALL_ONES, rand64()));
		send(make_req(ACT_ADD, ALL_ONES, ALL_ONES, rand64()));
		send(make_req(ACT_CANCEL, rand64(), rand64(), 64'd2));
		send(make_req(ACT_CANCEL, rand64(), rand64(), 64'd2));
		send(make_req(ACT_QUERY, far_dl - 64'd2147483647000, rand64(), rand64()));
		send(make_req(ACT_QUERY, far_dl - 64'd2147483646001, rand64(), rand64()));
		send(make_req(ACT_QUERY, far_dl - 64'd2147483646000, rand64(), rand64()));
		send(make_req(ACT_QUERY, 64'd0, rand64(), rand64()));
		send(make_req(ACT_FIRE, far_dl - 64'd1, rand64(), rand64()));
		send(make_req(ACT_FIRE, ALL_ONES, rand64(), rand64()));
		send(make_req(ACT_CANCEL, rand64(), rand64(), 64'd3));
		drain();

		// Random part in phases; some fill the table past full and then fire it, at times flushing it all.
		items_left = RANDOM_ITEMS;
		phase = 0;
		while (items_left > 0) begin
			calm = ($urandom_range(0, 3) == 0);
			if (phase == 0 || $urandom_range(0, 7) == 0) begin
				for (k = 0; k < DEPTH + 3; k++) begin
					send(make_req(ACT_ADD, clock_us, $urandom_range(0, 60000), rand64()));
					items_left--;
				end
				send(make_req(ACT_FIRE, $urandom_range(0, 1) ? ALL_ONES : clock_us + 64'd30000,
					rand64(), rand64()));
				items_left--;
			end else begin
				burst = $urandom_range(15, 40);
				for (k = 0; k < burst; k++) begin
					send(random_req());
					items_left--;
				end
			end
			if (phase == 4)
				drain();
			phase++;
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("** deadline_timer_table: PASSED **");
		else
			$display("** deadline_timer_table: FAILED **");
		$finish;
	end

endmodule

### sim.f
rtl/dtt_pkg.sv
rtl/dtt_ram.sv
rtl/deadline_timer_table.sv
rtl/dtt_checker.sv
tb/tb_top.sv
